[src/cwad_pkg.sv]
// ----------------------------------------------------------------------------
// cwad_pkg
// Shared widths, constants and types of the CUSUM window anomaly detector.
// ----------------------------------------------------------------------------
package cwad_pkg;

    localparam int WINDOW_LENGTH = 1000;

    localparam int LEVEL_W   = 16;
    localparam int OUT_CNT_W = 10;
    localparam int CNT_W     = $clog2(WINDOW_LENGTH + 1);
    // cusum + sample - reference - drift stays within +/- 2^17
    localparam int SUM_W     = LEVEL_W + 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [OUT_CNT_W-1:0] COUNT_SHOWN_MAX = '1;

    localparam logic [LEVEL_W-1:0] THRESHOLD_RESET = 16'd5734;
    localparam logic [LEVEL_W-1:0] DRIFT_RESET     = 16'd6144;
    localparam logic [LEVEL_W-1:0] REFERENCE_RESET = 16'd0;

    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIFT_ALLOWANCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE_LEVEL = 2'd2;

    // Per-beat control into the alarm window
    typedef struct packed {
        logic advance;
        logic alarm_bit;
    } win_ctrl_t;

endpackage

[src/cwad_window_cell.sv]
// ----------------------------------------------------------------------------
// cwad_window_cell
// One slot of the alarm window: holds one alarm bit, passes it on when the
// window advances.
// ----------------------------------------------------------------------------
module cwad_window_cell (
    input  logic aclk,
    input  logic aresetn,
    input  logic advance,
    input  logic bit_in,
    output logic bit_out
);

    logic bit_reg;
    logic bit_next;

    assign bit_next = advance ? bit_in : bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_reg <= 1'b0;
        end else begin
            bit_reg <= bit_next;
        end
    end

    assign bit_out = bit_reg;

endmodule

[src/cwad_alarm_window.sv]
// ----------------------------------------------------------------------------
// cwad_alarm_window
// Chain of window cells holding the last WINDOW_LENGTH alarm bits, with a
// running count of the ones in the chain.
// ----------------------------------------------------------------------------
module cwad_alarm_window (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cwad_pkg::win_ctrl_t           ctrl,
    output logic [cwad_pkg::OUT_CNT_W-1:0] count_shown_next
);

    import cwad_pkg::*;

    localparam int WIDE_W = (CNT_W > OUT_CNT_W) ? CNT_W : OUT_CNT_W;

    logic [WINDOW_LENGTH:0] chain;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [WIDE_W-1:0]      count_wide;

    assign chain[0] = ctrl.alarm_bit;

    for (genvar i = 0; i < WINDOW_LENGTH; i++) begin : g_cell
        cwad_window_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .advance (ctrl.advance),
            .bit_in  (chain[i]),
            .bit_out (chain[i+1])
        );
    end

    // Oldest bit drops out of the window as the new one enters
    always_comb begin
        count_next = count_reg;
        if (ctrl.advance) begin
            count_next = count_reg - CNT_W'(chain[WINDOW_LENGTH])
                         + CNT_W'(ctrl.alarm_bit);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign count_wide       = WIDE_W'(count_next);
    assign count_shown_next = (count_wide > WIDE_W'(COUNT_SHOWN_MAX))
                              ? COUNT_SHOWN_MAX : OUT_CNT_W'(count_wide);

endmodule

[src/cusum_window_anomaly_detector_core.sv]
// ----------------------------------------------------------------------------
// cusum_window_anomaly_detector_core
// One-sided CUSUM change detector with a sliding count of alarms.
// ----------------------------------------------------------------------------
// The result beat of an accepted input beat appears in the following cycle.
// Throughput: 1 beat per cycle; the level update and the one-cell window shift
// both finish in the accepting cycle, and the output register takes the next
// result as soon as the current one is taken.
// Reset: registers with a reset return to their reset values, level and window clear at once; result data has no reset.
module cusum_window_anomaly_detector_core (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cwad_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cwad_pkg::LEVEL_W-1:0]    cfg_wdata,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [cwad_pkg::LEVEL_W-1:0]    s_residual_norm,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_alarm,
    output logic [cwad_pkg::OUT_CNT_W-1:0]  m_alarm_count,
    output logic [cwad_pkg::LEVEL_W-1:0]    m_cusum_level
);

    import cwad_pkg::*;

    logic [LEVEL_W-1:0]   threshold_reg;
    logic [LEVEL_W-1:0]   drift_reg;
    logic [LEVEL_W-1:0]   reference_reg;
    logic [LEVEL_W-1:0]   cusum_reg;
    logic [LEVEL_W-1:0]   cusum_next;

    logic                 m_valid_reg;
    logic                 m_alarm_reg;
    logic [OUT_CNT_W-1:0] m_count_reg;
    logic [LEVEL_W-1:0]   m_level_reg;

    logic                 in_beat;
    logic [SUM_W-1:0]     sum;
    logic                 sum_neg;
    logic [SUM_W-2:0]     sum_mag;
    logic                 alarm_bit;
    win_ctrl_t            win_ctrl;
    logic [OUT_CNT_W-1:0] count_shown_next;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign in_beat   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RESET;
            drift_reg     <= DRIFT_RESET;
            reference_reg <= REFERENCE_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_ALARM_THRESHOLD: threshold_reg <= cfg_wdata;
                CFG_DRIFT_ALLOWANCE: drift_reg     <= cfg_wdata;
                CFG_REFERENCE_LEVEL: reference_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Two's complement sum; the width holds the full range of the terms
    assign sum = SUM_W'(cusum_reg) + SUM_W'(s_residual_norm)
               - SUM_W'(reference_reg) - SUM_W'(drift_reg);
    assign sum_neg   = sum[SUM_W-1];
    assign sum_mag   = sum[SUM_W-2:0];
    assign alarm_bit = !sum_neg && (sum_mag > (SUM_W-1)'(threshold_reg));

    // Clear on alarm or below zero; otherwise the level is at most the threshold
    assign cusum_next = (sum_neg || alarm_bit) ? '0 : sum_mag[LEVEL_W-1:0];

    assign win_ctrl.advance   = in_beat;
    assign win_ctrl.alarm_bit = alarm_bit;

    cwad_alarm_window u_window (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .ctrl             (win_ctrl),
        .count_shown_next (count_shown_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cusum_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (in_beat) begin
                cusum_reg <= cusum_next;
            end
            if (in_beat) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_beat) begin
            m_alarm_reg <= alarm_bit;
            m_count_reg <= count_shown_next;
            m_level_reg <= cusum_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_alarm       = m_alarm_reg;
    assign m_alarm_count = m_count_reg;
    assign m_cusum_level = m_level_reg;

endmodule

[tb/sv/cwad_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cwad_checker
// Watches the register, sample and result channels of the CUSUM window
// anomaly detector, keeps its own copy of the registers, the level and the
// alarm window, and compares every result beat with its prediction.
// ----------------------------------------------------------------------------
module cwad_checker (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [cwad_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cwad_pkg::LEVEL_W-1:0]    cfg_wdata,

    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic [cwad_pkg::LEVEL_W-1:0]    s_residual_norm,

    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic                            m_alarm,
    input  logic [cwad_pkg::OUT_CNT_W-1:0]  m_alarm_count,
    input  logic [cwad_pkg::LEVEL_W-1:0]    m_cusum_level,

    output int                              fail_count,
    output int                              pending_count,
    output int                              alarm_total
);
    import cwad_pkg::*;

    localparam int PAD_W       = SUM_W - LEVEL_W;

    typedef struct packed {
        logic                 alarm;
        logic [OUT_CNT_W-1:0] count;
        logic [LEVEL_W-1:0]   level;
    } detector_out_t;

    logic [LEVEL_W-1:0] threshold_q;
    logic [LEVEL_W-1:0] drift_q;
    logic [LEVEL_W-1:0] reference_q;
    logic [LEVEL_W-1:0] cusum_q;
    logic               alarm_window [WINDOW_LENGTH];
    int unsigned        slot;
    logic [CNT_W-1:0]   window_ones;

    detector_out_t      expected_outputs_q [$];
    detector_out_t      oldest;
    int                 errors = 0;
    int                 alarms = 0;

    function automatic logic signed [SUM_W-1:0] widen(input logic [LEVEL_W-1:0] value);
        return $signed({{PAD_W{1'b0}}, value});
    endfunction

    // One sample through the detector: level update, window slot, count.
    function automatic detector_out_t cusum_step(input logic [LEVEL_W-1:0] residual);
        logic signed [SUM_W-1:0] sum;
        detector_out_t           r;
        sum = widen(cusum_q) + widen(residual) - widen(reference_q) - widen(drift_q);
        if (sum < 0) begin
            sum = '0;
        end
        r.alarm = (sum > widen(threshold_q));
        cusum_q = r.alarm ? '0 : sum[LEVEL_W-1:0];
        // drop the bit that leaves the window, then add the new one
        if (alarm_window[slot] && window_ones != 0) begin
            window_ones = window_ones - 1'b1;
        end
        alarm_window[slot] = r.alarm;
        window_ones = window_ones + r.alarm;
        slot = (slot == WINDOW_LENGTH - 1) ? 0 : slot + 1;
        r.count = (window_ones > COUNT_SHOWN_MAX) ? COUNT_SHOWN_MAX
                                                  : window_ones[OUT_CNT_W-1:0];
        r.level = cusum_q;
        return r;
    endfunction

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: mismatch on %s: expected %0d, actual %0d",
                     $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            threshold_q = THRESHOLD_RESET;
            drift_q     = DRIFT_RESET;
            reference_q = REFERENCE_RESET;
            cusum_q     = '0;
            slot        = 0;
            window_ones = '0;
            for (int i = 0; i < WINDOW_LENGTH; i++) begin
                alarm_window[i] = 1'b0;
            end
            expected_outputs_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ALARM_THRESHOLD: threshold_q = cfg_wdata;
                    CFG_DRIFT_ALLOWANCE: drift_q     = cfg_wdata;
                    CFG_REFERENCE_LEVEL: reference_q = cfg_wdata;
                    default: ;
                endcase
            end
            // a result leaving now belongs to an older sample, so pop first
            if (m_valid && m_ready) begin
                if (m_alarm) begin
                    alarms++;
                end
                if (expected_outputs_q.size() == 0) begin
                    errors++;
                    $display({"%0t: result beat with nothing expected: expected none,",
                              " actual alarm %0d count %0d level %0d"},
                             $time, m_alarm, m_alarm_count, m_cusum_level);
                end else begin
                    oldest = expected_outputs_q.pop_front();
                    compare_field("alarm", oldest.alarm, m_alarm);
                    compare_field("alarm_count", oldest.count, m_alarm_count);
                    compare_field("cusum_level", oldest.level, m_cusum_level);
                end
            end
            if (s_valid && s_ready) begin
                expected_outputs_q.push_back(cusum_step(s_residual_norm));
            end
        end
        fail_count    <= errors;
        pending_count <= expected_outputs_q.size();
        alarm_total   <= alarms;
    end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the CUSUM window anomaly detector: directed
// threshold, clamp and wide-sum cases, then random phases under several
// register settings with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
    import cwad_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_NO_REGISTER = 2'd3;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_SAMPLES = 160;

    logic                 aclk            = 1'b0;
    logic                 aresetn         = 1'b0;
    logic                 cfg_valid       = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index       = '0;
    logic [LEVEL_W-1:0]   cfg_wdata       = '0;
    logic                 s_valid         = 1'b0;
    logic                 s_ready;
    logic [LEVEL_W-1:0]   s_residual_norm = '0;
    logic                 m_valid;
    logic                 m_ready         = 1'b0;
    logic                 m_alarm;
    logic [OUT_CNT_W-1:0] m_alarm_count;
    logic [LEVEL_W-1:0]   m_cusum_level;

    int fail_count;
    int pending_count;
    int alarm_total;
    int tx_idle_pct    = 0;
    int rx_idle_pct    = 0;
    int samples_sent   = 0;
    int settings_used  = 0;
    int stall_cycles   = 0;

    // current register values, used to steer the random samples
    logic [LEVEL_W-1:0] thr_now   = THRESHOLD_RESET;
    logic [LEVEL_W-1:0] drift_now = DRIFT_RESET;
    logic [LEVEL_W-1:0] ref_now   = REFERENCE_RESET;

    cusum_window_anomaly_detector_core uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_residual_norm (s_residual_norm),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_alarm         (m_alarm),
        .m_alarm_count   (m_alarm_count),
        .m_cusum_level   (m_cusum_level)
    );

    cwad_checker u_score (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_residual_norm (s_residual_norm),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_alarm         (m_alarm),
        .m_alarm_count   (m_alarm_count),
        .m_cusum_level   (m_cusum_level),
        .fail_count      (fail_count),
        .pending_count   (pending_count),
        .alarm_total     (alarm_total)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Hold cfg_valid high; the caller lowers it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEVEL_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic apply_settings(input logic [LEVEL_W-1:0] thr, input logic [LEVEL_W-1:0] drift,
                                  input logic [LEVEL_W-1:0] refl);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
        write_reg(CFG_NO_REGISTER, LEVEL_W'($urandom));
        write_reg(CFG_ALARM_THRESHOLD, thr);
        write_reg(CFG_DRIFT_ALLOWANCE, drift);
        write_reg(CFG_REFERENCE_LEVEL, refl);
        cfg_valid <= 1'b0;
        thr_now   = thr;
        drift_now = drift;
        ref_now   = refl;
        settings_used++;
    endtask

    task automatic send_sample(input logic [LEVEL_W-1:0] value);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_valid         <= 1'b1;
        s_residual_norm <= value;
        do @(posedge aclk); while (!s_ready);
        samples_sent++;
    endtask

    // Mostly samples just above reference + drift so the level climbs and
    // crosses the threshold now and then; the rest is noise and extremes.
    function automatic logic [LEVEL_W-1:0] draw_residual();
        int pick;
        int v;
        pick = $urandom_range(99);
        if (pick < 60) begin
            v = int'(ref_now) + int'(drift_now) - 256
                + int'($urandom_range((thr_now >> 2) + 1024));
        end else if (pick < 85) begin
            v = $urandom_range(65535);
        end else if (pick < 92) begin
            v = 0;
        end else begin
            v = 65535;
        end
        if (v < 0) begin
            v = 0;
        end else if (v > 65535) begin
            v = 65535;
        end
        return v[LEVEL_W-1:0];
    endfunction

    task automatic run_phase(input int n);
        repeat (n) send_sample(draw_residual());
    endtask

    initial begin
        tx_idle_pct = 27;
        rx_idle_pct <= 70;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // unmapped index must leave the reset values alone
        write_reg(CFG_NO_REGISTER, 16'hFFFF);
        cfg_valid <= 1'b0;

        // reset settings: extremes, level equal to threshold, one above, clamp
        send_sample(16'd0);
        send_sample(16'hFFFF);
        send_sample(LEVEL_W'(DRIFT_RESET + THRESHOLD_RESET));
        send_sample(LEVEL_W'(DRIFT_RESET + 1));
        send_sample(DRIFT_RESET);
        send_sample(LEVEL_W'(DRIFT_RESET - 1));

        // zero threshold: any positive level alarms, zero does not
        apply_settings(16'd0, 16'd0, 16'd0);
        send_sample(16'd0);
        send_sample(16'd1);
        send_sample(16'd0);

        // full-scale threshold: level reaches 65535, then the sum goes wide
        apply_settings(16'hFFFF, 16'd0, 16'd0);
        send_sample(16'hFFFF);
        send_sample(16'hFFFF);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'd1);

        // most negative sum
        apply_settings(LEVEL_W'($urandom), 16'hFFFF, 16'hFFFF);
        send_sample(16'd0);
        send_sample(16'hFFFF);

        apply_settings(LEVEL_W'($urandom_range(8000, 1000)), LEVEL_W'($urandom_range(8000)),
                       LEVEL_W'($urandom_range(8000)));
        run_phase(PHASE_SAMPLES);
        apply_settings(16'd0, 16'd0, LEVEL_W'($urandom));
        run_phase(PHASE_SAMPLES);

        tx_idle_pct = 70;
        rx_idle_pct <= 27;
        apply_settings(16'hFFFF, 16'd0, 16'd0);
        run_phase(PHASE_SAMPLES);
        apply_settings(LEVEL_W'($urandom), LEVEL_W'($urandom), LEVEL_W'($urandom));
        run_phase(PHASE_SAMPLES);

        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        apply_settings(THRESHOLD_RESET, DRIFT_RESET, REFERENCE_RESET);
        run_phase(PHASE_SAMPLES);

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);

        $display("Ran %0d samples under %0d register settings, %0d alarms raised.",
                 samples_sent, settings_used, alarm_total);
        $display("Alarm window of %0d slots wrapped %0d time(s); stalls on both sides.",
                 WINDOW_LENGTH, samples_sent / WINDOW_LENGTH);
        if (fail_count == 0 && pending_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
